// ===== rtl/bresenham_line_pixel_walker_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the line walker core
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_PIXEL_WALKER_CORE_MACROS_SVH
`define BRESENHAM_LINE_PIXEL_WALKER_CORE_MACROS_SVH

// same-cycle implication
`define BLW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line walker assertion failed");

// next-cycle implication
`define BLW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line walker assertion failed");

`endif

// ===== rtl/blw_pkg.sv =====
// ---------------------------------------------------------------------------
// blw_pkg
// Types and constants shared by the line walker modules.
// ---------------------------------------------------------------------------
`default_nettype none

package blw_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIM_W      = 12;
    localparam int COLOR_W    = 32;
    localparam int ADDR_W     = 24;
    localparam int INC_NS_W   = COORD_BITS + 2;
    localparam int DEC_W      = INC_NS_W + 1;
    localparam int PROD_W     = COORD_BITS + DIM_W;
    localparam int AREA_W     = 2 * DIM_W;
    localparam int FULL_W     = (PROD_W + 1 > ADDR_W) ? PROD_W + 1 : ADDR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(1920);
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(1080);

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        AXIS_VERT = 2'd0,
        AXIS_HORZ = 2'd1,
        AXIS_XMAJ = 2'd2,
        AXIS_YMAJ = 2'd3
    } axis_mode_t;

    typedef struct packed {
        op_t                        op;
        axis_mode_t                 mode;
        logic [COORD_BITS-1:0]      cur_x;
        logic [COORD_BITS-1:0]      cur_y;
        logic [COORD_BITS-1:0]      stop;
        logic                       neg;
        logic signed [DEC_W-1:0]    dec;
        logic [INC_NS_W-1:0]        inc_ns;
        logic signed [DEC_W-1:0]    inc_ws;
        logic [COLOR_W-1:0]         color;
    } line_cmd_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]      x;
        logic [COORD_BITS-1:0]      y;
        logic [COLOR_W-1:0]         color;
        logic                       last;
    } pix_t;

endpackage

`default_nettype wire

// ===== rtl/blw_front.sv =====
// ---------------------------------------------------------------------------
// blw_front
// Classifies a request: works out axis mode, start point, stop coordinate
// and the decision term set-up for a start; a step passes through.
// ---------------------------------------------------------------------------
`default_nettype none

module blw_front (
    input  wire logic                              operation,
    input  wire logic [blw_pkg::COORD_BITS-1:0]    start_x,
    input  wire logic [blw_pkg::COORD_BITS-1:0]    start_y,
    input  wire logic [blw_pkg::COORD_BITS-1:0]    end_x,
    input  wire logic [blw_pkg::COORD_BITS-1:0]    end_y,
    input  wire logic [blw_pkg::COLOR_W-1:0]       line_color,
    output blw_pkg::line_cmd_t                     cmd
);

    logic [blw_pkg::COORD_BITS-1:0] dx;
    logic [blw_pkg::COORD_BITS-1:0] dy;
    logic [blw_pkg::COORD_BITS-1:0] mn;
    logic [blw_pkg::COORD_BITS-1:0] mj;
    logic                           x_lt;
    logic                           y_lt;
    logic signed [blw_pkg::DEC_W-1:0] mn_e;
    logic signed [blw_pkg::DEC_W-1:0] mj_e;

    always_comb
    begin
        x_lt = start_x < end_x;
        y_lt = start_y < end_y;
        dx   = x_lt ? end_x - start_x : start_x - end_x;
        dy   = y_lt ? end_y - start_y : start_y - end_y;
        mn   = (dx > dy) ? dy : dx;
        mj   = (dx > dy) ? dx : dy;
        mn_e = signed'(blw_pkg::DEC_W'(mn));
        mj_e = signed'(blw_pkg::DEC_W'(mj));

        cmd        = '0;
        cmd.op     = blw_pkg::op_t'(operation);
        cmd.color  = line_color;

        if (dx == '0)
        begin
            cmd.mode  = blw_pkg::AXIS_VERT;
            cmd.cur_x = start_x;
            cmd.cur_y = y_lt ? start_y : end_y;
            cmd.stop  = y_lt ? end_y : start_y;
        end
        else if (dy == '0)
        begin
            cmd.mode  = blw_pkg::AXIS_HORZ;
            cmd.cur_y = start_y;
            cmd.cur_x = x_lt ? start_x : end_x;
            cmd.stop  = x_lt ? end_x : start_x;
        end
        else
        begin
            if (dx > dy)
            begin
                cmd.mode  = blw_pkg::AXIS_XMAJ;
                cmd.cur_x = x_lt ? start_x : end_x;
                cmd.cur_y = x_lt ? start_y : end_y;
                cmd.stop  = x_lt ? end_x : start_x;
                cmd.neg   = x_lt ? (start_y > end_y) : (end_y > start_y);
            end
            else
            begin
                cmd.mode  = blw_pkg::AXIS_YMAJ;
                cmd.cur_x = y_lt ? start_x : end_x;
                cmd.cur_y = y_lt ? start_y : end_y;
                cmd.stop  = y_lt ? end_y : start_y;
                cmd.neg   = y_lt ? (start_x > end_x) : (end_x > start_x);
            end
            cmd.inc_ns = {1'b0, mn, 1'b0};
            cmd.inc_ws = (mn_e - mj_e) <<< 1;
            cmd.dec    = (mn_e <<< 1) - mj_e;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/blw_queue.sv =====
// ---------------------------------------------------------------------------
// blw_queue
// Short register FIFO of classified requests between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module blw_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  blw_pkg::line_cmd_t      push_data,
    output logic                    full,
    input  wire logic               pop,
    output logic                    head_valid,
    output blw_pkg::line_cmd_t      head
);

    blw_pkg::line_cmd_t              mem_reg [blw_pkg::QDEPTH];
    logic [blw_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [blw_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [blw_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [blw_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [blw_pkg::QCNT_W-1:0]      count_reg;
    logic [blw_pkg::QCNT_W-1:0]      count_next;
    logic                            do_push;
    logic                            do_pop;

    localparam logic [blw_pkg::QPTR_W-1:0] PTR_LAST = blw_pkg::QPTR_W'(blw_pkg::QDEPTH - 1);
    localparam logic [blw_pkg::QCNT_W-1:0] CNT_FULL = blw_pkg::QCNT_W'(blw_pkg::QDEPTH);

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        do_push     = push && !full;
        do_pop      = pop && head_valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/blw_walker.sv =====
// ---------------------------------------------------------------------------
// blw_walker
// Back end walker: holds the line state, takes requests off the queue and
// steps one pixel a cycle into its free pixel register while steps are queued.
// ---------------------------------------------------------------------------
`default_nettype none

module blw_walker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  blw_pkg::line_cmd_t      head,
    output logic                    pop,
    output logic                    pix_valid,
    output blw_pkg::pix_t           pix,
    input  wire logic               pix_ready
);

    logic                               active_reg, active_next;
    blw_pkg::axis_mode_t                mode_reg, mode_next;
    logic [blw_pkg::COORD_BITS-1:0]     x_reg, x_next;
    logic [blw_pkg::COORD_BITS-1:0]     y_reg, y_next;
    logic [blw_pkg::COORD_BITS-1:0]     stop_reg, stop_next;
    logic                               neg_reg, neg_next;
    logic signed [blw_pkg::DEC_W-1:0]   dec_reg, dec_next;
    logic [blw_pkg::INC_NS_W-1:0]       ins_reg, ins_next;
    logic signed [blw_pkg::DEC_W-1:0]   iws_reg, iws_next;
    logic [blw_pkg::COLOR_W-1:0]        color_reg, color_next;
    logic                               pix_valid_reg, pix_valid_next;
    blw_pkg::pix_t                      pix_reg;
    logic                               slot_free;
    logic                               emit;
    logic                               last;
    logic                               dec_neg;
    logic signed [blw_pkg::DEC_W-1:0]   ins_s;

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;
    assign slot_free = !pix_valid_reg || pix_ready;

    always_comb
    begin
        active_next = active_reg;
        mode_next   = mode_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        stop_next   = stop_reg;
        neg_next    = neg_reg;
        dec_next    = dec_reg;
        ins_next    = ins_reg;
        iws_next    = iws_reg;
        color_next  = color_reg;
        pop         = 1'b0;
        emit        = 1'b0;
        dec_neg     = dec_reg[blw_pkg::DEC_W-1];
        ins_s       = signed'({1'b0, ins_reg});
        last        = (mode_reg inside {blw_pkg::AXIS_HORZ, blw_pkg::AXIS_XMAJ})
                      ? (x_reg == stop_reg) : (y_reg == stop_reg);

        if (head_valid)
        begin
            if (head.op == blw_pkg::OP_START)
            begin
                // a start drops whatever line was in progress
                pop         = 1'b1;
                active_next = 1'b1;
                mode_next   = head.mode;
                x_next      = head.cur_x;
                y_next      = head.cur_y;
                stop_next   = head.stop;
                neg_next    = head.neg;
                dec_next    = head.dec;
                ins_next    = head.inc_ns;
                iws_next    = head.inc_ws;
                color_next  = head.color;
            end
            else if (!active_reg)
            begin
                pop = 1'b1;
            end
            else if (slot_free)
            begin
                pop  = 1'b1;
                emit = 1'b1;
                if (last)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    case (mode_reg)
                        blw_pkg::AXIS_VERT:
                        begin
                            y_next = y_reg + 1'b1;
                        end
                        blw_pkg::AXIS_HORZ:
                        begin
                            x_next = x_reg + 1'b1;
                        end
                        blw_pkg::AXIS_XMAJ:
                        begin
                            x_next = x_reg + 1'b1;
                            if (dec_neg)
                            begin
                                dec_next = dec_reg + ins_s;
                            end
                            else
                            begin
                                y_next   = neg_reg ? y_reg - 1'b1 : y_reg + 1'b1;
                                dec_next = dec_reg + iws_reg;
                            end
                        end
                        default:
                        begin
                            y_next = y_reg + 1'b1;
                            if (dec_neg)
                            begin
                                dec_next = dec_reg + ins_s;
                            end
                            else
                            begin
                                x_next   = neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
                                dec_next = dec_reg + iws_reg;
                            end
                        end
                    endcase
                end
            end
        end
        pix_valid_next = emit || (pix_valid_reg && !pix_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            mode_reg      <= blw_pkg::AXIS_VERT;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            mode_reg      <= mode_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        stop_reg  <= stop_next;
        neg_reg   <= neg_next;
        dec_reg   <= dec_next;
        ins_reg   <= ins_next;
        iws_reg   <= iws_next;
        color_reg <= color_next;
        if (emit)
        begin
            pix_reg.x     <= x_reg;
            pix_reg.y     <= y_reg;
            pix_reg.color <= color_reg;
            pix_reg.last  <= last;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/blw_addr.sv =====
// ---------------------------------------------------------------------------
// blw_addr
// Address stages: row times pitch, then add column and test against the
// frame area, into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module blw_addr (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [blw_pkg::DIM_W-1:0]         frame_width,
    input  wire logic [blw_pkg::DIM_W-1:0]         frame_height,
    input  wire logic                              pix_valid,
    input  blw_pkg::pix_t                          pix,
    output logic                                   pix_ready,
    output logic                                   pixel_valid,
    input  wire logic                              pixel_ready,
    output logic [blw_pkg::COORD_BITS-1:0]         pixel_x,
    output logic [blw_pkg::COORD_BITS-1:0]         pixel_y,
    output logic [blw_pkg::ADDR_W-1:0]             pixel_address,
    output logic [blw_pkg::COLOR_W-1:0]            pixel_color,
    output logic                                   last_pixel,
    output logic                                   out_of_frame
);

    logic                               p2_valid_reg, p2_valid_next;
    blw_pkg::pix_t                      p2_pix_reg;
    logic [blw_pkg::PROD_W-1:0]         prod_reg;
    logic [blw_pkg::AREA_W-1:0]         area_reg;
    logic                               out_valid_reg, out_valid_next;
    logic [blw_pkg::COORD_BITS-1:0]     x_reg;
    logic [blw_pkg::COORD_BITS-1:0]     y_reg;
    logic [blw_pkg::ADDR_W-1:0]         addr_reg;
    logic [blw_pkg::COLOR_W-1:0]        color_reg;
    logic                               last_reg;
    logic                               oof_reg;
    logic                               out_free;
    logic                               p2_go;
    logic                               p1_go;
    logic [blw_pkg::FULL_W-1:0]         full_addr;

    assign out_free  = !out_valid_reg || pixel_ready;
    assign p2_go     = p2_valid_reg && out_free;
    assign pix_ready = !p2_valid_reg || out_free;
    assign p1_go     = pix_valid && pix_ready;
    assign full_addr = blw_pkg::FULL_W'(prod_reg) + blw_pkg::FULL_W'(p2_pix_reg.x);

    assign p2_valid_next  = p1_go || (p2_valid_reg && !out_free);
    assign out_valid_next = p2_go || (out_valid_reg && !pixel_ready);

    assign pixel_valid   = out_valid_reg;
    assign pixel_x       = x_reg;
    assign pixel_y       = y_reg;
    assign pixel_address = addr_reg;
    assign pixel_color   = color_reg;
    assign last_pixel    = last_reg;
    assign out_of_frame  = oof_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p2_valid_reg  <= p2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        // user changes config only while idle (unchecked), so area_reg is safe
        area_reg <= blw_pkg::AREA_W'(frame_width) * blw_pkg::AREA_W'(frame_height);
        if (p1_go)
        begin
            p2_pix_reg <= pix;
            prod_reg   <= blw_pkg::PROD_W'(pix.y) * blw_pkg::PROD_W'(frame_width);
        end
        if (p2_go)
        begin
            x_reg     <= p2_pix_reg.x;
            y_reg     <= p2_pix_reg.y;
            color_reg <= p2_pix_reg.color;
            last_reg  <= p2_pix_reg.last;
            addr_reg  <= full_addr[blw_pkg::ADDR_W-1:0];
            oof_reg   <= full_addr >= blw_pkg::FULL_W'(area_reg);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bresenham_line_pixel_walker_core.sv =====
// Path: a step request passes the queue, the walker's pixel register, the
// address product register and the output register. Throughput: one request
// per cycle, starts and steps alike, while the pixel side does not stall.
// Reset (rst_n, async, active low): walker idle, queue and pipe empty,
// frame size back to 1920 x 1080.
// ---------------------------------------------------------------------------
// bresenham_line_pixel_walker_core
// Top level: classifying front, request queue, walker and address stages.
// ---------------------------------------------------------------------------
`default_nettype none

module bresenham_line_pixel_walker_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire logic                              operation,
    input  wire logic [blw_pkg::COORD_BITS-1:0]    start_x,
    input  wire logic [blw_pkg::COORD_BITS-1:0]    start_y,
    input  wire logic [blw_pkg::COORD_BITS-1:0]    end_x,
    input  wire logic [blw_pkg::COORD_BITS-1:0]    end_y,
    input  wire logic [blw_pkg::COLOR_W-1:0]       line_color,
    output logic                                   pixel_valid,
    input  wire logic                              pixel_ready,
    output logic [blw_pkg::COORD_BITS-1:0]         pixel_x,
    output logic [blw_pkg::COORD_BITS-1:0]         pixel_y,
    output logic [blw_pkg::ADDR_W-1:0]             pixel_address,
    output logic [blw_pkg::COLOR_W-1:0]            pixel_color,
    output logic                                   last_pixel,
    output logic                                   out_of_frame,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [blw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [blw_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [blw_pkg::DIM_W-1:0]  fw_reg, fw_next;
    logic [blw_pkg::DIM_W-1:0]  fh_reg, fh_next;
    blw_pkg::line_cmd_t         front_cmd;
    blw_pkg::line_cmd_t         head;
    logic                       q_full;
    logic                       head_valid;
    logic                       pop;
    logic                       pix_valid;
    logic                       pix_ready;
    blw_pkg::pix_t              pix;

    assign cfg_ready  = 1'b1;
    assign item_ready = !q_full;

    always_comb
    begin
        fw_next = fw_reg;
        fh_next = fh_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                blw_pkg::REG_FRAME_WIDTH:  fw_next = cfg_data[blw_pkg::DIM_W-1:0];
                blw_pkg::REG_FRAME_HEIGHT: fh_next = cfg_data[blw_pkg::DIM_W-1:0];
                default:
                begin
                    // unknown index: write dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= blw_pkg::FRAME_WIDTH_RST;
            fh_reg <= blw_pkg::FRAME_HEIGHT_RST;
        end
        else
        begin
            fw_reg <= fw_next;
            fh_reg <= fh_next;
        end
    end

    blw_front u_front (
        .operation  (operation),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .line_color (line_color),
        .cmd        (front_cmd)
    );

    blw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (item_valid),
        .push_data  (front_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    blw_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .pix_valid  (pix_valid),
        .pix        (pix),
        .pix_ready  (pix_ready)
    );

    blw_addr u_addr (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_width   (fw_reg),
        .frame_height  (fh_reg),
        .pix_valid     (pix_valid),
        .pix           (pix),
        .pix_ready     (pix_ready),
        .pixel_valid   (pixel_valid),
        .pixel_ready   (pixel_ready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .last_pixel    (last_pixel),
        .out_of_frame  (out_of_frame)
    );

endmodule

`default_nettype wire

// ===== rtl/blw_checker.sv =====
// ---------------------------------------------------------------------------
// blw_checker
// Port-level checks on the line walker core, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bresenham_line_pixel_walker_core_macros.svh"

module blw_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              pixel_valid,
    input wire logic                              pixel_ready,
    input wire logic [blw_pkg::COORD_BITS-1:0]    pixel_x,
    input wire logic [blw_pkg::ADDR_W-1:0]        pixel_address,
    input wire logic [blw_pkg::COLOR_W-1:0]       pixel_color,
    input wire logic                              last_pixel,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready
);

    // stalled pixel request holds
    `BLW_ASSERT_NEXT(a_pix_hold, pixel_valid && !pixel_ready, pixel_valid && $stable(pixel_x) && $stable(pixel_address) && $stable(pixel_color) && $stable(last_pixel))

    // address is row times pitch plus column and never wraps
    `BLW_ASSERT_NOW(a_addr_ge_x, pixel_valid, pixel_address >= blw_pkg::ADDR_W'(pixel_x))

    // config writes are never back-pressured
    `BLW_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind bresenham_line_pixel_walker_core blw_checker u_blw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pixel_valid   (pixel_valid),
    .pixel_ready   (pixel_ready),
    .pixel_x       (pixel_x),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last_pixel    (last_pixel),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);

`default_nettype wire

// ===== test/pixel_walk_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line walker pixel checker
// Watches the request, pixel and register channels of the line walker. Keeps
// its own copy of the walker state and frame size, works out the pixel that
// each accepted step request must produce, and compares every accepted pixel
// in order against the oldest one still waiting.
// ----------------------------------------------------------------------------
module pixel_walk_checker
    import blw_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  logic                    item_ready,
    input  logic                    operation,
    input  logic [COORD_BITS-1:0]   start_x,
    input  logic [COORD_BITS-1:0]   start_y,
    input  logic [COORD_BITS-1:0]   end_x,
    input  logic [COORD_BITS-1:0]   end_y,
    input  logic [COLOR_W-1:0]      line_color,
    input  logic                    pixel_valid,
    input  logic                    pixel_ready,
    input  logic [COORD_BITS-1:0]   pixel_x,
    input  logic [COORD_BITS-1:0]   pixel_y,
    input  logic [ADDR_W-1:0]       pixel_address,
    input  logic [COLOR_W-1:0]      pixel_color,
    input  logic                    last_pixel,
    input  logic                    out_of_frame,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output int                      mismatches,
    output int                      outstanding
);

    typedef struct {
        logic [COORD_BITS-1:0]  x;
        logic [COORD_BITS-1:0]  y;
        logic [ADDR_W-1:0]      addr;
        logic [COLOR_W-1:0]     color;
        logic                   last;
        logic                   oof;
    } walk_pixel_t;

    walk_pixel_t                expected_pixels[$];

    logic [DIM_W-1:0]           frame_w;
    logic [DIM_W-1:0]           frame_h;

    logic                       walk_active;
    axis_mode_t                 walk_mode;
    logic [COORD_BITS-1:0]      pos_x;
    logic [COORD_BITS-1:0]      pos_y;
    logic [COORD_BITS-1:0]      end_coord;
    logic                       minor_down;
    logic signed [DEC_W-1:0]    err_term;
    logic [INC_NS_W-1:0]        err_inc_flat;
    logic signed [DEC_W-1:0]    err_inc_diag;
    logic [COLOR_W-1:0]         walk_color;

    task automatic load_line();
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        dx = (start_x > end_x) ? start_x - end_x : end_x - start_x;
        dy = (start_y > end_y) ? start_y - end_y : end_y - start_y;
        walk_color   = line_color;
        walk_active  = 1'b1;
        minor_down   = 1'b0;
        err_term     = '0;
        err_inc_flat = '0;
        err_inc_diag = '0;
        if (dx == 0)
        begin
            walk_mode = AXIS_VERT;
            pos_x     = start_x;
            pos_y     = (start_y < end_y) ? start_y : end_y;
            end_coord = (start_y < end_y) ? end_y : start_y;
        end
        else if (dy == 0)
        begin
            walk_mode = AXIS_HORZ;
            pos_y     = start_y;
            pos_x     = (start_x < end_x) ? start_x : end_x;
            end_coord = (start_x < end_x) ? end_x : start_x;
        end
        else if (dx > dy)
        begin
            walk_mode = AXIS_XMAJ;
            if (start_x < end_x)
            begin
                pos_x      = start_x;
                pos_y      = start_y;
                end_coord  = end_x;
                minor_down = start_y > end_y;
            end
            else
            begin
                pos_x      = end_x;
                pos_y      = end_y;
                end_coord  = start_x;
                minor_down = end_y > start_y;
            end
            err_inc_flat = INC_NS_W'(2 * int'(dy));
            err_inc_diag = DEC_W'(2 * (int'(dy) - int'(dx)));
            err_term     = DEC_W'(2 * int'(dy) - int'(dx));
        end
        else
        begin
            // equal spans fall here too: a 45 degree line walks along y
            walk_mode = AXIS_YMAJ;
            if (start_y < end_y)
            begin
                pos_x      = start_x;
                pos_y      = start_y;
                end_coord  = end_y;
                minor_down = start_x > end_x;
            end
            else
            begin
                pos_x      = end_x;
                pos_y      = end_y;
                end_coord  = start_y;
                minor_down = end_x > start_x;
            end
            err_inc_flat = INC_NS_W'(2 * int'(dx));
            err_inc_diag = DEC_W'(2 * (int'(dx) - int'(dy)));
            err_term     = DEC_W'(2 * int'(dx) - int'(dy));
        end
    endtask

    task automatic step_line();
        logic [FULL_W-1:0] full;
        logic              at_end;
        walk_pixel_t       px;
        full   = FULL_W'(pos_y) * FULL_W'(frame_w) + FULL_W'(pos_x);
        at_end = (walk_mode == AXIS_HORZ || walk_mode == AXIS_XMAJ) ?
                 (pos_x == end_coord) : (pos_y == end_coord);
        px.x     = pos_x;
        px.y     = pos_y;
        px.addr  = full[ADDR_W-1:0];
        px.color = walk_color;
        px.last  = at_end;
        px.oof   = full >= FULL_W'(frame_w) * FULL_W'(frame_h);
        expected_pixels = {expected_pixels, px};
        if (at_end)
        begin
            walk_active = 1'b0;
        end
        else
        begin
            case (walk_mode)
                AXIS_VERT: pos_y = pos_y + 1'b1;
                AXIS_HORZ: pos_x = pos_x + 1'b1;
                AXIS_XMAJ:
                begin
                    pos_x = pos_x + 1'b1;
                    if (err_term < 0)
                    begin
                        err_term = err_term + $signed({1'b0, err_inc_flat});
                    end
                    else
                    begin
                        pos_y    = minor_down ? pos_y - 1'b1 : pos_y + 1'b1;
                        err_term = err_term + err_inc_diag;
                    end
                end
                default:
                begin
                    pos_y = pos_y + 1'b1;
                    if (err_term < 0)
                    begin
                        err_term = err_term + $signed({1'b0, err_inc_flat});
                    end
                    else
                    begin
                        pos_x    = minor_down ? pos_x - 1'b1 : pos_x + 1'b1;
                        err_term = err_term + err_inc_diag;
                    end
                end
            endcase
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    task automatic check_pixel();
        walk_pixel_t px;
        if (expected_pixels.size() == 0)
        begin
            $error("pixel (%0d,%0d) emitted with no step request waiting",
                   pixel_x, pixel_y);
            mismatches++;
        end
        else
        begin
            px = expected_pixels.pop_front();
            check_field("pixel_x", 32'(px.x), 32'(pixel_x));
            check_field("pixel_y", 32'(px.y), 32'(pixel_y));
            check_field("pixel_address", 32'(px.addr), 32'(pixel_address));
            check_field("pixel_color", px.color, pixel_color);
            check_field("last_pixel", 32'(px.last), 32'(last_pixel));
            check_field("out_of_frame", 32'(px.oof), 32'(out_of_frame));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_pixels.delete();
            frame_w      = FRAME_WIDTH_RST;
            frame_h      = FRAME_HEIGHT_RST;
            walk_active  = 1'b0;
            walk_mode    = AXIS_VERT;
            pos_x        = '0;
            pos_y        = '0;
            end_coord    = '0;
            minor_down   = 1'b0;
            err_term     = '0;
            err_inc_flat = '0;
            err_inc_diag = '0;
            walk_color   = '0;
            mismatches   = 0;
            outstanding  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_w = cfg_data[DIM_W-1:0];
                    REG_FRAME_HEIGHT: frame_h = cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            // pixels out now belong to older requests, so compare first
            if (pixel_valid && pixel_ready)
                check_pixel();
            if (item_valid && item_ready)
            begin
                if (operation == OP_START)
                    load_line();
                else if (walk_active)
                    step_line();
            end
            outstanding = expected_pixels.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line walker testbench
// Drives start and step requests into the line walker: a directed opening,
// then phases of random lines under several frame sizes, with random gaps on
// the request side and random stalls on the pixel side. Checking is done by
// the pixel walk checker; this module builds the stimulus and the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import blw_pkg::*;

    // indexes past the register list; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 110;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_ready;
    op_t                    item_op;
    logic [COORD_BITS-1:0]  start_x;
    logic [COORD_BITS-1:0]  start_y;
    logic [COORD_BITS-1:0]  end_x;
    logic [COORD_BITS-1:0]  end_y;
    logic [COLOR_W-1:0]     line_color;
    logic                   pixel_valid;
    logic                   pixel_ready;
    logic [COORD_BITS-1:0]  pixel_x;
    logic [COORD_BITS-1:0]  pixel_y;
    logic [ADDR_W-1:0]      pixel_address;
    logic [COLOR_W-1:0]     pixel_color;
    logic                   last_pixel;
    logic                   out_of_frame;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     mismatches;
    int                     outstanding;
    bit                     sender_gaps;
    bit                     receiver_stalls;
    int                     items_sent;
    int                     items_target;
    int                     quiet_cycles;

    bresenham_line_pixel_walker_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .operation     (item_op),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .line_color    (line_color),
        .pixel_valid   (pixel_valid),
        .pixel_ready   (pixel_ready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .last_pixel    (last_pixel),
        .out_of_frame  (out_of_frame),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pixel_walk_checker pixel_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .operation     (item_op),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .line_color    (line_color),
        .pixel_valid   (pixel_valid),
        .pixel_ready   (pixel_ready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .last_pixel    (last_pixel),
        .out_of_frame  (out_of_frame),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // pixel side back-pressure: random bursts with ready low
    initial
    begin
        pixel_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (receiver_stalls && $urandom_range(0, 5) == 0) begin
                pixel_ready = 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge clk);
            end else begin
                pixel_ready = 1'b1;
            end
        end
    end

    // nothing accepted on any channel for too long means a hang
    always @(posedge clk) begin
        if (!rst_n || (item_valid && item_ready) || (pixel_valid && pixel_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_request(input op_t op, input logic [COORD_BITS-1:0] ax,
                                input logic [COORD_BITS-1:0] ay,
                                input logic [COORD_BITS-1:0] bx,
                                input logic [COORD_BITS-1:0] by,
                                input logic [COLOR_W-1:0] colour);
        @(negedge clk);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        item_valid = 1'b1;
        item_op    = op;
        start_x    = ax;
        start_y    = ay;
        end_x      = bx;
        end_y      = by;
        line_color = colour;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    // endpoint fields of a step are don't-care, so they carry noise
    task automatic send_step();
        send_request(OP_STEP, COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                     COORD_BITS'($urandom()), COORD_BITS'($urandom()), $urandom());
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // drain: all pixels back, then a settling wait for starts still in the pipe
    task automatic wait_idle();
        @(negedge clk);
        item_valid = 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    task automatic random_line();
        int kind;
        int span;
        int ax;
        int ay;
        int bx;
        int by;
        int d;
        int len;
        int steps;
        kind = $urandom_range(0, 99);
        span = (kind < 70) ? $urandom_range(0, 12) :
               (kind < 85) ? $urandom_range(13, 100) : COORD_MAX;
        // each start coordinate near the origin half the time so small frames see in-frame pixels
        ax = $urandom_range(0, 1) ? $urandom_range(0, 127) : $urandom_range(0, COORD_MAX);
        ay = $urandom_range(0, 1) ? $urandom_range(0, 127) : $urandom_range(0, COORD_MAX);
        if ($urandom_range(0, 9) == 0)
            ax = $urandom_range(0, 1) ? COORD_MAX : 0;
        if ($urandom_range(0, 9) == 0)
            ay = $urandom_range(0, 1) ? COORD_MAX : 0;
        bx = clamp_coord(ax + int'($urandom_range(0, 2 * span)) - span);
        by = clamp_coord(ay + int'($urandom_range(0, 2 * span)) - span);
        case ($urandom_range(0, 9))
            0: bx = ax;
            1: by = ay;
            2:
            begin
                d  = (bx > ax) ? bx - ax : ax - bx;
                by = (ay + d <= COORD_MAX) ? ay + d : clamp_coord(ay - d);
            end
            3:
            begin
                bx = ax;
                by = ay;
            end
            default: ;
        endcase
        len = (bx > ax) ? bx - ax : ax - bx;
        d   = (by > ay) ? by - ay : ay - by;
        len = ((d > len) ? d : len) + 1;
        if (len > 300) begin
            steps = $urandom_range(1, 64);
        end else begin
            case ($urandom_range(0, 9))
                0: steps = $urandom_range(0, len - 1);
                1: steps = len + $urandom_range(1, 2);
                default: steps = len;
            endcase
        end
        send_request(OP_START, COORD_BITS'(ax), COORD_BITS'(ay), COORD_BITS'(bx),
                     COORD_BITS'(by), $urandom());
        repeat (steps) send_step();
        items_sent += 1 + ((steps < len) ? steps : len);
    endtask

    task automatic send_noise();
        send_request(op_t'($urandom_range(0, 1)), COORD_BITS'($urandom()),
                     COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                     COORD_BITS'($urandom()), $urandom());
    endtask

    initial
    begin
        rst_n           = 1'b0;
        item_valid      = 1'b0;
        item_op         = OP_STEP;
        start_x         = '0;
        start_y         = '0;
        end_x           = '0;
        end_y           = '0;
        line_color      = '0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_FRAME_WIDTH;
        cfg_data        = '0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        items_sent      = 0;
        items_target    = 0;
        quiet_cycles    = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed opening under the reset frame size
        send_step();                                            // idle: no pixel
        send_request(OP_START, 0, 0, 0, 0, 32'h0000_0000);      // single point
        send_step();
        send_request(OP_START, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF);
        send_step();                                            // off the frame
        send_request(OP_START, 7, 3, 7, 1, 32'hA5A5_A5A5);      // vertical, upwards
        repeat (3) send_step();
        send_request(OP_START, 4095, 100, 4093, 100, 32'h5A5A_5A5A);
        repeat (3) send_step();
        send_request(OP_START, 3, 0, 0, 2, 32'h1234_5678);      // x-major, y falling
        repeat (4) send_step();
        send_request(OP_START, 1, 0, 0, 3, 32'h8765_4321);      // y-major, x falling
        send_step();
        send_request(OP_START, 0, 4095, 4095, 0, 32'hC0FF_EE00); // abandons the line
        repeat (2) send_step();
        send_request(OP_START, 0, 0, 4095, 4094, 32'h0F0F_0F0F);
        send_step();

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0:
                begin
                    write_reg(REG_FRAME_WIDTH, 32'd4095);
                    write_reg(REG_FRAME_HEIGHT, 32'd4095);
                end
                1:
                begin
                    write_reg(REG_FRAME_WIDTH, 32'd1);
                    write_reg(REG_FRAME_HEIGHT, 32'd1);
                end
                2:
                begin
                    write_reg(REG_FRAME_WIDTH, 32'hFFFF_F000);  // low bits zero
                    write_reg(REG_FRAME_HEIGHT, $urandom());
                end
                3:
                begin
                    write_reg(REG_FRAME_WIDTH, $urandom());
                    write_reg(REG_FRAME_HEIGHT, 32'h0000_1000);
                    write_reg(REG_SPARE_LO, $urandom());
                    write_reg(REG_SPARE_HI, $urandom());
                end
                4:
                begin
                    write_reg(REG_FRAME_WIDTH, 32'd1);
                    write_reg(REG_FRAME_HEIGHT, 32'd4095);
                end
                5:
                begin
                    write_reg(REG_FRAME_WIDTH, 32'd4095);
                    write_reg(REG_FRAME_HEIGHT, 32'd1);
                    write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
                end
                default:
                begin
                    write_reg(REG_FRAME_WIDTH, $urandom_range(1, 128));
                    write_reg(REG_FRAME_HEIGHT, $urandom_range(1, 128));
                end
            endcase
            sender_gaps     = (phase < PHASES - 1) ? $urandom_range(0, 1) : 1'b0;
            receiver_stalls = (phase < PHASES - 1) ? $urandom_range(0, 1) : 1'b0;
            items_target += PHASE_ITEMS;
            while (items_sent < items_target) begin
                if (phase < PHASES - 1 && $urandom_range(0, 19) == 0) begin
                    sender_gaps     = $urandom_range(0, 1);
                    receiver_stalls = $urandom_range(0, 1);
                end
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                    random_line();
            end
        end

        @(negedge clk);
        item_valid = 1'b0;
        wait (outstanding == 0);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
